// ===== rtl/loc_pkg.sv =====
// Shared constants, codes and memory word types of the lock-order checker.
`timescale 1ns / 1ps
package loc_pkg;
    localparam int TYPE_BITS    = 6;
    localparam int NTYPES       = 1 << TYPE_BITS;
    localparam int STACK_DEPTH  = 16;
    localparam int STACK_AW     = 4;
    localparam int SITE_ENTRIES = 256;
    localparam int SITE_AW      = 8;
    localparam int CNT_W        = SITE_AW + 1;
    localparam logic [31:0] STATIC_SITE = 32'hFFFF_FFFF;

    localparam logic [2:0] OP_REG  = 3'd0;
    localparam logic [2:0] OP_ACQ  = 3'd1;
    localparam logic [2:0] OP_END  = 3'd2;
    localparam logic [2:0] OP_REL  = 3'd3;
    localparam logic [2:0] OP_STAT = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_NOT_HELD = 3'd2;
    localparam logic [2:0] ST_TBL_FULL = 3'd3;
    localparam logic [2:0] ST_BAD_IDX  = 3'd4;

    // type entry and the order row of that type share one word
    typedef struct packed {
        logic [31:0]       site;
        logic              pre;
        logic [NTYPES-1:0] order;
    } t_tmem_word;

    typedef struct packed {
        logic [TYPE_BITS-1:0] rd_addr;
        logic                 wr_en;
        logic [TYPE_BITS-1:0] wr_addr;
        t_tmem_word           wr_data;
    } t_tmem_req;

    // use-site key and its stats share one word
    typedef struct packed {
        logic [TYPE_BITS-1:0] stype;
        logic [31:0]          addr;
        logic [63:0]          total;
        logic [31:0]          uses;
        logic [63:0]          peak;
    } t_smem_word;

    typedef struct packed {
        logic [SITE_AW-1:0] rd_addr;
        logic               wr_en;
        logic [SITE_AW-1:0] wr_addr;
        t_smem_word         wr_data;
    } t_smem_req;
endpackage

// ===== rtl/loc_in_if.sv =====
// Input item channel of the lock-order checker.
`timescale 1ns / 1ps
interface loc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [31:0] lock_handle;
    logic [31:0] lock_site;
    logic [5:0]  type_id;
    logic        preemptible;
    logic [31:0] call_site;
    logic [7:0]  stat_index;
    logic [63:0] acq_ticks;
    logic [63:0] now_ticks;
    modport source (output valid, operation, lock_handle, lock_site, type_id, preemptible,
                    call_site, stat_index, acq_ticks, now_ticks, input ready);
    modport sink (input valid, operation, lock_handle, lock_site, type_id, preemptible,
                  call_site, stat_index, acq_ticks, now_ticks, output ready);
endinterface

// ===== rtl/loc_out_if.sv =====
// Result channel of the lock-order checker.
`timescale 1ns / 1ps
interface loc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [5:0]  type_out;
    logic [7:0]  stat_out;
    logic        deadlock;
    logic        inversion;
    logic [5:0]  conflict_type;
    logic [63:0] total_ticks;
    logic [31:0] use_count;
    logic [63:0] peak_ticks;
    modport source (output valid, status, type_out, stat_out, deadlock, inversion,
                    conflict_type, total_ticks, use_count, peak_ticks, input ready);
    modport sink (input valid, status, type_out, stat_out, deadlock, inversion,
                  conflict_type, total_ticks, use_count, peak_ticks, output ready);
endinterface

// ===== rtl/loc_cfg_if.sv =====
// Configuration write channel (enable register).
`timescale 1ns / 1ps
interface loc_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== rtl/loc_tmem.sv =====
// Type table with order matrix rows, one synchronous read port.
`timescale 1ns / 1ps
module loc_tmem (
    input  logic               i_clk,
    input  loc_pkg::t_tmem_req i_req,
    output loc_pkg::t_tmem_word o_rd_data
);
    import loc_pkg::*;

    t_tmem_word r_mem [NTYPES];
    t_tmem_word r_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd <= r_mem[i_req.rd_addr];
    end

    assign o_rd_data = r_rd;
endmodule

// ===== rtl/loc_smem.sv =====
// Use-site table with stats, one synchronous read port.
`timescale 1ns / 1ps
module loc_smem (
    input  logic               i_clk,
    input  loc_pkg::t_smem_req i_req,
    output loc_pkg::t_smem_word o_rd_data
);
    import loc_pkg::*;

    t_smem_word r_mem [SITE_ENTRIES];
    t_smem_word r_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd <= r_mem[i_req.rd_addr];
    end

    assign o_rd_data = r_rd;
endmodule

// ===== rtl/lock_order_checker.sv =====
// Top level: lock-order checker sequencer, held stack and result register.
`timescale 1ns / 1ps
// One item is worked at a time by a sequencer around two memories, each
// with one synchronous read port (types with their order rows, use sites
// with their stats). Register-type searches the type entries and appends
// one if none matches; acquire start checks or appends its type, searches
// or appends its use site, then updates the order row of each held entry,
// skipping other instances of its type; acquire end and read stats read
// one site entry (acquire end updates it) or finish on a bad index; release
// searches the held entries. The final state waits while the result
// register is full; it lets the next item be accepted while a result waits.
// The order rows reset through a valid bit per row; no clearing pass.
module lock_order_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    loc_in_if.sink    i_in,
    loc_cfg_if.sink   i_cfg,
    loc_out_if.source o_res
);
    import loc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TSCAN = 4'd1;
    localparam logic [3:0] S_TCMP  = 4'd2;
    localparam logic [3:0] S_ACHK  = 4'd3;
    localparam logic [3:0] S_AAPP  = 4'd4;
    localparam logic [3:0] S_ASITE = 4'd5;
    localparam logic [3:0] S_ASCMP = 4'd6;
    localparam logic [3:0] S_AHELD = 4'd7;
    localparam logic [3:0] S_AROW  = 4'd8;
    localparam logic [3:0] S_ALOOP = 4'd9;
    localparam logic [3:0] S_AUPD  = 4'd10;
    localparam logic [3:0] S_SRD   = 4'd11;
    localparam logic [3:0] S_RSCAN = 4'd12;
    localparam logic [3:0] S_FIN   = 4'd13;

    localparam logic [TYPE_BITS:0] TYPE_LIMIT = (TYPE_BITS+1)'(NTYPES);
    localparam logic [SITE_AW:0]   SITE_LIMIT = (SITE_AW+1)'(SITE_ENTRIES);
    localparam logic [STACK_AW:0]  HELD_LIMIT = (STACK_AW+1)'(STACK_DEPTH);

    // control
    logic [3:0]             r_state, n_state;
    logic                   r_enable, n_enable;
    logic [TYPE_BITS:0]     r_type_used, n_type_used;
    logic [SITE_AW:0]       r_site_used, n_site_used;
    logic [STACK_AW:0]      r_held_size, n_held_size;
    logic [NTYPES-1:0]      r_row_valid, n_row_valid;
    logic                   r_o_valid, n_o_valid;
    // item
    logic [2:0]             r_op, n_op;
    logic [31:0]            r_handle, n_handle;
    logic [31:0]            r_site, n_site;
    logic [TYPE_BITS-1:0]   r_tid, n_tid;
    logic                   r_pre, n_pre;
    logic [31:0]            r_csite, n_csite;
    logic [SITE_AW-1:0]     r_sidx, n_sidx;
    logic [63:0]            r_ticks, n_ticks;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_ptid, n_ptid;
    logic [NTYPES-1:0]      r_rowtid, n_rowtid;
    logic [TYPE_BITS-1:0]   r_h, n_h;
    logic                   r_rep, n_rep;
    // held stack
    logic [31:0]            r_hh [STACK_DEPTH];
    logic [31:0]            n_hh [STACK_DEPTH];
    logic [TYPE_BITS-1:0]   r_ht [STACK_DEPTH];
    logic [TYPE_BITS-1:0]   n_ht [STACK_DEPTH];
    // working result
    logic [2:0]             r_status, n_status;
    logic [TYPE_BITS-1:0]   r_type_out, n_type_out;
    logic [SITE_AW-1:0]     r_stat_out, n_stat_out;
    logic                   r_dl, n_dl;
    logic                   r_inv, n_inv;
    logic [TYPE_BITS-1:0]   r_conf, n_conf;
    logic [63:0]            r_total, n_total;
    logic [31:0]            r_uses, n_uses;
    logic [63:0]            r_peak, n_peak;
    // result register
    logic [2:0]             r_o_status, n_o_status;
    logic [TYPE_BITS-1:0]   r_o_type, n_o_type;
    logic [SITE_AW-1:0]     r_o_stat, n_o_stat;
    logic                   r_o_dl, n_o_dl;
    logic                   r_o_inv, n_o_inv;
    logic [TYPE_BITS-1:0]   r_o_conf, n_o_conf;
    logic [63:0]            r_o_total, n_o_total;
    logic [31:0]            r_o_uses, n_o_uses;
    logic [63:0]            r_o_peak, n_o_peak;

    t_tmem_req  s_treq;
    t_tmem_word s_trd;
    t_smem_req  s_sreq;
    t_smem_word s_srd;
    logic       s_rel_hit;

    loc_tmem u_tmem (.i_clk(i_clk), .i_req(s_treq), .o_rd_data(s_trd));
    loc_smem u_smem (.i_clk(i_clk), .i_req(s_sreq), .o_rd_data(s_srd));

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign s_rel_hit   = (r_state == S_RSCAN) && (r_cnt < CNT_W'(r_held_size))
                         && (r_hh[r_cnt[STACK_AW-1:0]] == r_handle);

    always_comb begin
        logic [NTYPES-1:0]    v_row;
        logic                 v_inv;
        logic                 v_dl;
        logic [63:0]          v_sum;
        logic [TYPE_BITS-1:0] v_h;
        logic [31:0]          v_hd;
        logic [STACK_AW-1:0]  v_top;

        n_state = r_state;   n_enable = r_enable;   n_type_used = r_type_used;
        n_site_used = r_site_used;   n_held_size = r_held_size;
        n_row_valid = r_row_valid;   n_o_valid = r_o_valid && !o_res.ready;
        n_op = r_op;   n_handle = r_handle;   n_site = r_site;   n_tid = r_tid;
        n_pre = r_pre;   n_csite = r_csite;   n_sidx = r_sidx;   n_ticks = r_ticks;
        n_cnt = r_cnt;   n_ptid = r_ptid;   n_rowtid = r_rowtid;   n_h = r_h;
        n_rep = r_rep;   n_hh = r_hh;   n_ht = r_ht;
        n_status = r_status;   n_type_out = r_type_out;   n_stat_out = r_stat_out;
        n_dl = r_dl;   n_inv = r_inv;   n_conf = r_conf;
        n_total = r_total;   n_uses = r_uses;   n_peak = r_peak;
        n_o_status = r_o_status;   n_o_type = r_o_type;   n_o_stat = r_o_stat;
        n_o_dl = r_o_dl;   n_o_inv = r_o_inv;   n_o_conf = r_o_conf;
        n_o_total = r_o_total;   n_o_uses = r_o_uses;   n_o_peak = r_o_peak;
        s_treq = '0;
        s_sreq = '0;
        v_row = r_row_valid[r_h] ? s_trd.order : '0;
        v_inv = r_ptid && !s_trd.pre;
        v_dl  = r_rowtid[r_h] || (r_h == r_tid);
        v_sum = s_srd.total + r_ticks;
        v_h   = r_ht[r_cnt[STACK_AW-1:0]];
        v_hd  = r_hh[r_cnt[STACK_AW-1:0]];
        v_top = r_held_size[STACK_AW-1:0] - 1'b1;

        if (i_cfg.valid) begin
            n_enable = i_cfg.data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op = i_in.operation;   n_handle = i_in.lock_handle;
                    n_site = i_in.lock_site;   n_tid = i_in.type_id;
                    n_pre = i_in.preemptible;   n_csite = i_in.call_site;
                    n_sidx = i_in.stat_index;
                    n_ticks = i_in.now_ticks - i_in.acq_ticks;
                    n_cnt = '0;   n_rep = 1'b0;
                    n_status = ST_OK;   n_type_out = '0;   n_stat_out = '0;
                    n_dl = 1'b0;   n_inv = 1'b0;   n_conf = '0;
                    n_total = '0;   n_uses = '0;   n_peak = '0;
                    priority if (i_in.operation == OP_REG) begin
                        n_state = S_TSCAN;
                    end else if (i_in.operation == OP_ACQ && r_enable) begin
                        if ({1'b0, i_in.type_id} < r_type_used) begin
                            s_treq.rd_addr = i_in.type_id;
                            n_state = S_ACHK;
                        end else begin
                            n_state = S_AAPP;
                        end
                    end else if ((i_in.operation == OP_END && r_enable)
                                 || i_in.operation == OP_STAT) begin
                        if ({1'b0, i_in.stat_index} < r_site_used) begin
                            s_sreq.rd_addr = i_in.stat_index;
                            n_state = S_SRD;
                        end else begin
                            n_status = ST_BAD_IDX;
                            n_state = S_FIN;
                        end
                    end else if (i_in.operation == OP_REL && r_enable) begin
                        n_state = S_RSCAN;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_TSCAN: begin
                priority if (r_cnt < CNT_W'(r_type_used)) begin
                    s_treq.rd_addr = r_cnt[TYPE_BITS-1:0];
                    n_state = S_TCMP;
                end else if (r_type_used < TYPE_LIMIT) begin
                    s_treq.wr_en = 1'b1;
                    s_treq.wr_addr = r_type_used[TYPE_BITS-1:0];
                    s_treq.wr_data = '{site: r_site, pre: r_pre, order: '0};
                    n_type_out = r_type_used[TYPE_BITS-1:0];
                    n_type_used = r_type_used + 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_status = ST_TBL_FULL;
                    n_state = S_FIN;
                end
            end
            S_TCMP: begin
                if (s_trd.site == r_site) begin
                    n_type_out = r_cnt[TYPE_BITS-1:0];
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                    n_state = S_TSCAN;
                end
            end
            S_ACHK: begin
                if (s_trd.site == r_site) begin
                    n_ptid = s_trd.pre;
                    n_type_out = r_tid;
                    n_state = S_ASITE;
                end else begin
                    n_state = S_AAPP;
                end
            end
            S_AAPP: begin
                // stale type: append a static, non-preemptible type
                if (r_type_used < TYPE_LIMIT) begin
                    s_treq.wr_en = 1'b1;
                    s_treq.wr_addr = r_type_used[TYPE_BITS-1:0];
                    s_treq.wr_data = '{site: STATIC_SITE, pre: 1'b0, order: '0};
                    n_tid = r_type_used[TYPE_BITS-1:0];
                    n_type_out = r_type_used[TYPE_BITS-1:0];
                    n_ptid = 1'b0;
                    n_type_used = r_type_used + 1'b1;
                    n_state = S_ASITE;
                end else begin
                    n_status = ST_TBL_FULL;
                    n_state = S_FIN;
                end
            end
            S_ASITE: begin
                priority if (r_cnt < CNT_W'(r_site_used)) begin
                    s_sreq.rd_addr = r_cnt[SITE_AW-1:0];
                    n_state = S_ASCMP;
                end else if (r_site_used < SITE_LIMIT) begin
                    s_sreq.wr_en = 1'b1;
                    s_sreq.wr_addr = r_site_used[SITE_AW-1:0];
                    s_sreq.wr_data = '{stype: r_tid, addr: r_csite, total: '0,
                                       uses: '0, peak: '0};
                    n_stat_out = r_site_used[SITE_AW-1:0];
                    n_site_used = r_site_used + 1'b1;
                    n_state = S_AHELD;
                end else begin
                    n_status = ST_TBL_FULL;
                    n_state = S_FIN;
                end
            end
            S_ASCMP: begin
                if (s_srd.stype == r_tid && s_srd.addr == r_csite) begin
                    n_stat_out = r_cnt[SITE_AW-1:0];
                    n_state = S_AHELD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                    n_state = S_ASITE;
                end
            end
            S_AHELD: begin
                if (r_held_size >= HELD_LIMIT) begin
                    n_status = ST_FULL;
                    n_state = S_FIN;
                end else begin
                    s_treq.rd_addr = r_tid;
                    n_cnt = '0;
                    n_state = S_AROW;
                end
            end
            S_AROW: begin
                n_rowtid = r_row_valid[r_tid] ? s_trd.order : '0;
                n_state = S_ALOOP;
            end
            S_ALOOP: begin
                if (r_cnt < CNT_W'(r_held_size)) begin
                    if (v_h == r_tid && v_hd != r_handle) begin
                        n_cnt = r_cnt + 1'b1;   // other instance of same type
                    end else begin
                        n_h = v_h;
                        s_treq.rd_addr = v_h;
                        n_state = S_AUPD;
                    end
                end else begin
                    n_hh[r_held_size[STACK_AW-1:0]] = r_handle;
                    n_ht[r_held_size[STACK_AW-1:0]] = r_tid;
                    n_held_size = r_held_size + 1'b1;
                    n_state = S_FIN;
                end
            end
            S_AUPD: begin
                // set held->new; written before the next row read is issued
                s_treq.wr_en = 1'b1;
                s_treq.wr_addr = r_h;
                s_treq.wr_data = '{site: s_trd.site, pre: s_trd.pre,
                                   order: v_row | (NTYPES'(1) << r_tid)};
                n_row_valid[r_h] = 1'b1;
                if (v_inv) n_inv = 1'b1;
                if (v_dl) n_dl = 1'b1;
                if ((v_inv || v_dl) && !r_rep) begin
                    n_conf = r_h;
                    n_rep = 1'b1;
                end
                n_cnt = r_cnt + 1'b1;
                n_state = S_ALOOP;
            end
            S_SRD: begin
                n_stat_out = r_sidx;
                if (r_op == OP_STAT) begin
                    n_type_out = s_srd.stype;
                    n_total = s_srd.total;
                    n_uses = s_srd.uses;
                    n_peak = s_srd.peak;
                end else begin
                    s_sreq.wr_en = 1'b1;
                    s_sreq.wr_addr = r_sidx;
                    s_sreq.wr_data = '{stype: s_srd.stype, addr: s_srd.addr, total: v_sum,
                                       uses: s_srd.uses + 1'b1,
                                       peak: (r_ticks > s_srd.peak) ? r_ticks : s_srd.peak};
                end
                n_state = S_FIN;
            end
            S_RSCAN: begin
                priority if (s_rel_hit) begin
                    // swap-remove: top entry moves into the freed slot
                    n_hh[r_cnt[STACK_AW-1:0]] = r_hh[v_top];
                    n_ht[r_cnt[STACK_AW-1:0]] = r_ht[v_top];
                    n_held_size = r_held_size - 1'b1;
                    n_state = S_FIN;
                end else if (r_cnt < CNT_W'(r_held_size)) begin
                    n_cnt = r_cnt + 1'b1;
                end else begin
                    n_status = ST_NOT_HELD;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_o_valid || o_res.ready) begin
                    n_o_valid = 1'b1;
                    n_o_status = r_status;   n_o_type = r_type_out;   n_o_stat = r_stat_out;
                    n_o_dl = r_dl;   n_o_inv = r_inv;   n_o_conf = r_conf;
                    n_o_total = r_total;   n_o_uses = r_uses;   n_o_peak = r_peak;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;   r_enable <= 1'b0;   r_type_used <= '0;
            r_site_used <= '0;   r_held_size <= '0;   r_row_valid <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;   r_enable <= n_enable;   r_type_used <= n_type_used;
            r_site_used <= n_site_used;   r_held_size <= n_held_size;
            r_row_valid <= n_row_valid;   r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;   r_handle <= n_handle;   r_site <= n_site;   r_tid <= n_tid;
        r_pre <= n_pre;   r_csite <= n_csite;   r_sidx <= n_sidx;   r_ticks <= n_ticks;
        r_cnt <= n_cnt;   r_ptid <= n_ptid;   r_rowtid <= n_rowtid;   r_h <= n_h;
        r_rep <= n_rep;   r_hh <= n_hh;   r_ht <= n_ht;
        r_status <= n_status;   r_type_out <= n_type_out;   r_stat_out <= n_stat_out;
        r_dl <= n_dl;   r_inv <= n_inv;   r_conf <= n_conf;
        r_total <= n_total;   r_uses <= n_uses;   r_peak <= n_peak;
        r_o_status <= n_o_status;   r_o_type <= n_o_type;   r_o_stat <= n_o_stat;
        r_o_dl <= n_o_dl;   r_o_inv <= n_o_inv;   r_o_conf <= n_o_conf;
        r_o_total <= n_o_total;   r_o_uses <= n_o_uses;   r_o_peak <= n_o_peak;
    end

    assign o_res.valid         = r_o_valid;
    assign o_res.status        = r_o_status;
    assign o_res.type_out      = r_o_type;
    assign o_res.stat_out      = r_o_stat;
    assign o_res.deadlock      = r_o_dl;
    assign o_res.inversion     = r_o_inv;
    assign o_res.conflict_type = r_o_conf;
    assign o_res.total_ticks   = r_o_total;
    assign o_res.use_count     = r_o_uses;
    assign o_res.peak_ticks    = r_o_peak;

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_size <= HELD_LIMIT)
        else $error("held stack overflow");

    a_tbl_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_type_used <= TYPE_LIMIT && r_site_used <= SITE_LIMIT)
        else $error("table fill count out of range");

    a_release_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_rel_hit |=> r_held_size == $past(r_held_size) - 1'b1)
        else $error("release did not shrink held stack");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_o_valid && !o_res.ready) |=> r_state == S_FIN)
        else $error("result lost while output stalled");
endmodule
